### hdl/yuvrgb_pkg.sv
// Shared types, constants and a helper function for the YUV 4:2:0 to RGBA pixel writer.
`default_nettype none
package yuvrgb_pkg;

   // Design constants
   localparam int MAX_STRIDE     = 4096;
   localparam int COEF_FRAC_BITS = 10;

   localparam int CSR_W   = 13;                    // widest config register
   localparam int CSR_IDX_W = 2;
   localparam int COL_W   = $clog2(MAX_STRIDE);    // column_count width
   localparam int ROW_W   = 13;                    // row_count width
   localparam int CMP_W   = (COL_W + 1 > CSR_W) ? COL_W + 1 : CSR_W;
   localparam int PIX_W   = 8;
   localparam int IDX_W   = 24;
   localparam int IDXP_W  = ROW_W + CSR_W;         // row * dest_row_pixels
   localparam int DIFF_W  = PIX_W + 2;             // signed chroma offset
   localparam int COEF_W  = COEF_FRAC_BITS + 2;    // signed Q coefficient
   localparam int SUM_W   = COEF_W + DIFF_W;       // product / channel sum width

   localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};
   localparam logic [PIX_W-1:0] ALPHA   = 8'hFF;
   localparam logic [PIX_W-1:0] CH_MAX  = 8'hFF;
   localparam logic signed [DIFF_W-1:0] CHROMA_OFS = DIFF_W'(128);

   // Coefficients, round(c * 2^F) with c given in 1/10000 units
   localparam logic signed [COEF_W-1:0] K_R =
      COEF_W'((longint'(14065) * (longint'(1) << COEF_FRAC_BITS) + 5000) / 10000);
   localparam logic signed [COEF_W-1:0] K_GU =
      COEF_W'((longint'(3455) * (longint'(1) << COEF_FRAC_BITS) + 5000) / 10000);
   localparam logic signed [COEF_W-1:0] K_GV =
      COEF_W'((longint'(7169) * (longint'(1) << COEF_FRAC_BITS) + 5000) / 10000);
   localparam logic signed [COEF_W-1:0] K_B =
      COEF_W'((longint'(17790) * (longint'(1) << COEF_FRAC_BITS) + 5000) / 10000);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LUMA_ROW_STRIDE = 2'd0,
      CSR_DEST_ROW_PIXELS = 2'd1,
      CSR_DEST_HEIGHT     = 2'd2,
      CSR_FRAME_START     = 2'd3
   } yuvrgb_csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] chroma_u;
      logic [PIX_W-1:0] chroma_v;
   } yuvrgb_req_type;

   typedef struct packed {
      logic [31:0]      rgba_word;
      logic [IDX_W-1:0] dest_index;
      logic             dest_write;
   } yuvrgb_rsp_type;

   // One classified pixel waiting for conversion
   typedef struct packed {
      yuvrgb_req_type   pix;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             write;
   } yuvrgb_job_type;

   typedef struct packed {
      logic [CSR_W-1:0] dest_row_pixels;
   } yuvrgb_cfg_type;

   // Negative gives 0, else drop fraction and cap at 255
   function automatic logic [PIX_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
      logic [PIX_W-1:0] ch;
      if (sum[SUM_W-1]) begin
         ch = '0;
      end else if (|sum[SUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
         ch = CH_MAX;
      end else begin
         ch = sum[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
      end
      return ch;
   endfunction

endpackage
`default_nettype wire

### hdl/yuvrgb_front.sv
// Front end: config registers, raster counters and per-pixel write classification.
`default_nettype none
module yuvrgb_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire yuvrgb_pkg::yuvrgb_req_type             req_payload,
   input  wire logic                                   csr_write_en,
   input  wire logic [yuvrgb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [yuvrgb_pkg::CSR_W-1:0]           csr_wdata,
   output logic                                        push_valid,
   input  wire logic                                   push_ready,
   output yuvrgb_pkg::yuvrgb_job_type                  push_job,
   output yuvrgb_pkg::yuvrgb_cfg_type                  cfg
);

   logic [yuvrgb_pkg::CSR_W-1:0] luma_stride_ff, luma_stride_in;
   logic [yuvrgb_pkg::CSR_W-1:0] dest_pixels_ff, dest_pixels_in;
   logic [yuvrgb_pkg::CSR_W-1:0] dest_height_ff, dest_height_in;
   logic [yuvrgb_pkg::COL_W-1:0] column_ff, column_in;
   logic [yuvrgb_pkg::ROW_W-1:0] row_ff, row_in;

   logic                          accept;
   logic                          frame_clear;
   logic                          row_wrap;
   logic [yuvrgb_pkg::CMP_W-1:0]  eff_stride;
   logic [yuvrgb_pkg::CMP_W-1:0]  stride_ext;
   logic [yuvrgb_pkg::CMP_W-1:0]  col_next_ext;
   logic [yuvrgb_pkg::CMP_W-1:0]  col_ext;
   logic [yuvrgb_pkg::CMP_W-1:0]  pixels_ext;
   yuvrgb_pkg::yuvrgb_csr_index_type csr_sel;

   assign req_stall  = !push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign csr_sel    = yuvrgb_pkg::yuvrgb_csr_index_type'(csr_index);
   assign cfg.dest_row_pixels = dest_pixels_ff;

   // Config decode
   always_comb begin
      luma_stride_in = luma_stride_ff;
      dest_pixels_in = dest_pixels_ff;
      dest_height_in = dest_height_ff;
      frame_clear    = 1'b0;
      if (csr_write_en) begin
         unique case (csr_sel)
            yuvrgb_pkg::CSR_LUMA_ROW_STRIDE: luma_stride_in = csr_wdata;
            yuvrgb_pkg::CSR_DEST_ROW_PIXELS: dest_pixels_in = csr_wdata;
            yuvrgb_pkg::CSR_DEST_HEIGHT:     dest_height_in = csr_wdata;
            yuvrgb_pkg::CSR_FRAME_START:     frame_clear    = csr_wdata[0];
         endcase
      end
   end

   // Stride of zero acts as one, above the max acts as the max
   always_comb begin
      stride_ext = yuvrgb_pkg::CMP_W'(luma_stride_ff);
      if (stride_ext == '0) begin
         eff_stride = yuvrgb_pkg::CMP_W'(1);
      end else if (stride_ext > yuvrgb_pkg::CMP_W'(yuvrgb_pkg::MAX_STRIDE)) begin
         eff_stride = yuvrgb_pkg::CMP_W'(yuvrgb_pkg::MAX_STRIDE);
      end else begin
         eff_stride = stride_ext;
      end
   end

   assign col_ext      = yuvrgb_pkg::CMP_W'(column_ff);
   assign col_next_ext = col_ext + yuvrgb_pkg::CMP_W'(1);
   assign row_wrap     = col_next_ext >= eff_stride;
   assign pixels_ext   = yuvrgb_pkg::CMP_W'(dest_pixels_ff);

   always_comb begin
      push_job.pix    = req_payload;
      push_job.column = column_ff;
      push_job.row    = row_ff;
      push_job.write  = (col_ext < pixels_ext) && (row_ff < dest_height_ff);
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (frame_clear) begin
         column_in = '0;
         row_in    = '0;
      end else if (accept) begin
         if (row_wrap) begin
            column_in = '0;
            if (row_ff != yuvrgb_pkg::ROW_MAX) begin
               row_in = row_ff + yuvrgb_pkg::ROW_W'(1);
            end
         end else begin
            column_in = col_next_ext[yuvrgb_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_stride_ff <= yuvrgb_pkg::CSR_W'(1);
         dest_pixels_ff <= yuvrgb_pkg::CSR_W'(1);
         dest_height_ff <= yuvrgb_pkg::CSR_W'(1);
         column_ff      <= '0;
         row_ff         <= '0;
      end else begin
         luma_stride_ff <= luma_stride_in;
         dest_pixels_ff <= dest_pixels_in;
         dest_height_ff <= dest_height_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
      end
   end

endmodule
`default_nettype wire

### hdl/yuvrgb_fifo.sv
// Short queue of classified pixel words between the front and back ends.
`default_nettype none
module yuvrgb_fifo (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push_valid,
   output logic                             push_ready,
   input  wire yuvrgb_pkg::yuvrgb_job_type  push_job,
   output logic                             pop_valid,
   input  wire logic                        pop_ready,
   output yuvrgb_pkg::yuvrgb_job_type       pop_job
);

   yuvrgb_pkg::yuvrgb_job_type            entry_ff [yuvrgb_pkg::FIFO_DEPTH];
   logic [yuvrgb_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [yuvrgb_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [yuvrgb_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                                  push;
   logic                                  pop;

   assign push_ready = count_ff != yuvrgb_pkg::FIFO_CNT_W'(yuvrgb_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + yuvrgb_pkg::FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + yuvrgb_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + yuvrgb_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - yuvrgb_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= yuvrgb_pkg::FIFO_CNT_W'(yuvrgb_pkg::FIFO_DEPTH))
      else $error("queue count above depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + yuvrgb_pkg::FIFO_CNT_W'(1)))
      else $error("queue count did not rise on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[yuvrgb_pkg::FIFO_PTR_W-1:0])
      else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

### hdl/yuvrgb_back.sv
// Back end: two-stage color conversion and destination index, with registered output.
`default_nettype none
module yuvrgb_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pop_valid,
   output logic                             pop_ready,
   input  wire yuvrgb_pkg::yuvrgb_job_type  pop_job,
   input  wire yuvrgb_pkg::yuvrgb_cfg_type  cfg,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output yuvrgb_pkg::yuvrgb_rsp_type       rsp_payload
);

   // Stage 1: products
   logic                                         s1_valid_ff, s1_valid_in;
   logic signed [yuvrgb_pkg::SUM_W-1:0]          s1_base_ff, s1_base_in;
   logic signed [yuvrgb_pkg::SUM_W-1:0]          s1_r_ff, s1_r_in;
   logic signed [yuvrgb_pkg::SUM_W-1:0]          s1_gu_ff, s1_gu_in;
   logic signed [yuvrgb_pkg::SUM_W-1:0]          s1_gv_ff, s1_gv_in;
   logic signed [yuvrgb_pkg::SUM_W-1:0]          s1_b_ff, s1_b_in;
   logic [yuvrgb_pkg::IDXP_W-1:0]                s1_prod_ff, s1_prod_in;
   logic [yuvrgb_pkg::COL_W-1:0]                 s1_col_ff, s1_col_in;
   logic                                         s1_write_ff, s1_write_in;

   // Output register
   logic                                         out_valid_ff, out_valid_in;
   yuvrgb_pkg::yuvrgb_rsp_type                   out_ff, out_in;

   logic                                         out_load;
   logic                                         s1_load;
   logic signed [yuvrgb_pkg::DIFF_W-1:0]         du;
   logic signed [yuvrgb_pkg::DIFF_W-1:0]         dv;
   logic signed [yuvrgb_pkg::SUM_W-1:0]          sum_r, sum_g, sum_b;
   logic [yuvrgb_pkg::IDXP_W-1:0]                idx_full;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || out_load;
   assign pop_ready = s1_load;

   assign du = $signed({2'b00, pop_job.pix.chroma_u}) - yuvrgb_pkg::CHROMA_OFS;
   assign dv = $signed({2'b00, pop_job.pix.chroma_v}) - yuvrgb_pkg::CHROMA_OFS;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_base_in  = s1_base_ff;
      s1_r_in     = s1_r_ff;
      s1_gu_in    = s1_gu_ff;
      s1_gv_in    = s1_gv_ff;
      s1_b_in     = s1_b_ff;
      s1_prod_in  = s1_prod_ff;
      s1_col_in   = s1_col_ff;
      s1_write_in = s1_write_ff;
      if (s1_load) begin
         s1_valid_in = pop_valid;
         s1_base_in  = $signed(yuvrgb_pkg::SUM_W'({pop_job.pix.luma,
                                                   {yuvrgb_pkg::COEF_FRAC_BITS{1'b0}}}));
         s1_r_in     = yuvrgb_pkg::SUM_W'(yuvrgb_pkg::K_R)  * yuvrgb_pkg::SUM_W'(dv);
         s1_gu_in    = yuvrgb_pkg::SUM_W'(yuvrgb_pkg::K_GU) * yuvrgb_pkg::SUM_W'(du);
         s1_gv_in    = yuvrgb_pkg::SUM_W'(yuvrgb_pkg::K_GV) * yuvrgb_pkg::SUM_W'(dv);
         s1_b_in     = yuvrgb_pkg::SUM_W'(yuvrgb_pkg::K_B)  * yuvrgb_pkg::SUM_W'(du);
         s1_prod_in  = yuvrgb_pkg::IDXP_W'(pop_job.row) *
                       yuvrgb_pkg::IDXP_W'(cfg.dest_row_pixels);
         s1_col_in   = pop_job.column;
         s1_write_in = pop_job.write;
      end
   end

   assign sum_r    = s1_base_ff + s1_r_ff;
   assign sum_g    = s1_base_ff - s1_gu_ff - s1_gv_ff;
   assign sum_b    = s1_base_ff + s1_b_ff;
   assign idx_full = s1_prod_ff + yuvrgb_pkg::IDXP_W'(s1_col_ff);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_load) begin
         out_valid_in          = s1_valid_ff;
         out_in.rgba_word      = {yuvrgb_pkg::ALPHA,
                                  yuvrgb_pkg::clamp_channel(sum_r),
                                  yuvrgb_pkg::clamp_channel(sum_g),
                                  yuvrgb_pkg::clamp_channel(sum_b)};
         out_in.dest_index     = s1_write_ff ? idx_full[yuvrgb_pkg::IDX_W-1:0] : '0;
         out_in.dest_write     = s1_write_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_base_ff  <= s1_base_in;
      s1_r_ff     <= s1_r_in;
      s1_gu_ff    <= s1_gu_in;
      s1_gv_ff    <= s1_gv_in;
      s1_b_ff     <= s1_b_in;
      s1_prod_ff  <= s1_prod_in;
      s1_col_ff   <= s1_col_in;
      s1_write_ff <= s1_write_in;
      out_ff      <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && rsp_stall) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("stage one lost a word under stall");

   a_no_pop_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && rsp_stall) |-> !pop_ready)
      else $error("pop taken while pipeline full");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.dest_write) |-> (out_ff.dest_index == '0))
      else $error("index set on a skipped pixel");

endmodule
`default_nettype wire

### hdl/yuv420_to_rgba_pixel_writer.sv
// Top level of the YUV 4:2:0 to RGBA pixel writer.
// One pixel word per cycle sustained: a word is taken every clock while the
// four-entry queue has room, and each result passes through the queue write
// at the accepting edge, the multiply stage and the output register on its
// way to the result port. The front end holds the raster column/row counters
// and classifies each pixel as inside or outside the bitmap; the back end
// multiplies the chroma offsets by the Q10 coefficients and row by
// destination row pixels in one stage, then sums, clamps and forms the
// destination index in the next. A stall on the result side fills the queue
// before it reaches the request side. Write config only while idle;
// frame_start clears the counters.
`default_nettype none
module yuv420_to_rgba_pixel_writer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire yuvrgb_pkg::yuvrgb_req_type          req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output yuvrgb_pkg::yuvrgb_rsp_type               rsp_payload,
   input  wire logic                                csr_write_en,
   input  wire logic [yuvrgb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [yuvrgb_pkg::CSR_W-1:0]        csr_wdata
);

   logic                          push_valid;
   logic                          push_ready;
   yuvrgb_pkg::yuvrgb_job_type    push_job;
   logic                          pop_valid;
   logic                          pop_ready;
   yuvrgb_pkg::yuvrgb_job_type    pop_job;
   yuvrgb_pkg::yuvrgb_cfg_type    cfg;

   yuvrgb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_job     (push_job),
      .cfg          (cfg)
   );

   yuvrgb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   yuvrgb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
